// ===== hdl/median_of_two_sorted_lists_macros.svh =====
// Assertion macros for the median_of_two_sorted_lists checker.
// Expects clk and rst_n in the scope of use.
`ifndef MEDIAN_OF_TWO_SORTED_LISTS_MACROS_SVH
`define MEDIAN_OF_TWO_SORTED_LISTS_MACROS_SVH

// same-cycle implication
`define MED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MED_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/med_pkg.sv =====
// Shared types and constants for the median_of_two_sorted_lists block.
// No dependencies.
`default_nettype none

package med_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] a;
    } pair_t;

endpackage

`default_nettype wire

// ===== hdl/med_queue.sv =====
// Two-entry job queue between the load front end and the search engine.
// No package dependencies.
`default_nettype none

module med_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output logic              empty
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/med_front.sv =====
// Load front end: accepts pairs, writes them to the list memories, counts,
// and queues a search job on the final pair. Depends on med_pkg.
`default_nettype none

module med_front
    import med_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int JW    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire pair_t         s_axis_tdata,
    input  wire logic          s_axis_tlast,
    input  wire logic          q_full,
    output logic               q_push,
    output logic [JW-1:0]      q_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output pair_t              wr_data,
    input  wire logic          unlock
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          locked_reg, locked_next;
    logic          accept;
    logic          room;

    assign s_axis_tready = !locked_reg && !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = (cnt_reg < CW'(DEPTH));

    assign wr_en   = accept && room;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = s_axis_tdata;

    // job: {overflow, last index}
    assign q_push = accept && s_axis_tlast;
    assign q_data = {ovf_reg || !room, room ? cnt_reg[AW-1:0] : AW'(DEPTH - 1)};

    always_comb
    begin
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        locked_next = locked_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                cnt_next    = '0;
                ovf_next    = 1'b0;
                locked_next = 1'b1;
            end
            else if (room)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (unlock)
        begin
            locked_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            locked_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            locked_reg <= locked_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/med_back.sv =====
// Search engine: holds the two list memories and runs the halving search
// for each queued job, then registers the result. Depends on med_pkg.
`default_nettype none

module med_back
    import med_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int JW    = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire pair_t              wr_data,
    input  wire logic               q_empty,
    input  wire logic [JW-1:0]      q_data,
    output logic                    q_pop,
    output logic                    unlock,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [DATA_W-1:0]       m_axis_tdata,
    output logic                    m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     lo1_reg, lo1_next, hi1_reg, hi1_next;
    logic [AW-1:0]     lo2_reg, lo2_next, hi2_reg, hi2_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_median_reg, out_median_next;
    logic              out_ovf_reg, out_ovf_next;

    logic [AW:0]       sum1, sum2;
    logic [AW-1:0]     m1, m2;
    logic              odd_len;
    logic              range_done;
    logic              a_less;

    assign sum1       = {1'b0, lo1_reg} + {1'b0, hi1_reg};
    assign sum2       = {1'b0, lo2_reg} + {1'b0, hi2_reg};
    assign m1         = sum1[AW:1];
    assign m2         = sum2[AW:1];
    assign odd_len    = !sum1[0];
    assign range_done = (lo1_reg == hi1_reg) && (lo2_reg == hi2_reg);
    assign a_less     = ($signed(rd_a_reg) < $signed(rd_b_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data.a;
            mem_b[wr_addr] <= wr_data.b;
        end
        rd_a_reg <= mem_a[m1];
        rd_b_reg <= mem_b[m2];
    end

    assign q_pop         = (state_reg == ST_IDLE) && !q_empty && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_median_reg;
    assign m_axis_tuser  = out_ovf_reg;

    always_comb
    begin
        state_next      = state_reg;
        lo1_next        = lo1_reg;
        hi1_next        = hi1_reg;
        lo2_next        = lo2_reg;
        hi2_next        = hi2_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_median_next = out_median_reg;
        out_ovf_next    = out_ovf_reg;
        unlock          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    lo1_next   = '0;
                    lo2_next   = '0;
                    hi1_next   = q_data[AW-1:0];
                    hi2_next   = q_data[AW-1:0];
                    ovf_next   = q_data[JW-1];
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (range_done || (rd_a_reg == rd_b_reg))
                begin
                    out_median_next = (range_done && !a_less) ? rd_b_reg : rd_a_reg;
                    out_ovf_next    = ovf_reg;
                    out_valid_next  = 1'b1;
                    unlock          = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    if (a_less)
                    begin
                        lo1_next = odd_len ? m1 : m1 + AW'(1);
                        hi2_next = m2;
                    end
                    else
                    begin
                        lo2_next = odd_len ? m2 : m2 + AW'(1);
                        hi1_next = m1;
                    end
                    state_next = ST_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo1_reg        <= lo1_next;
        hi1_reg        <= hi1_next;
        lo2_reg        <= lo2_next;
        hi2_reg        <= hi2_next;
        ovf_reg        <= ovf_next;
        out_median_reg <= out_median_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/median_of_two_sorted_lists.sv =====
// Top level of the lower-median search over two sorted lists.
// Instantiates med_front, med_queue and med_back; depends on med_pkg.
//
// Usage:
//   s_axis carries one pair per request: element i of list A and of list B.
//   s_axis_tlast marks the final pair of a load and starts the search.
//   Loading takes one pair per cycle. Pairs past DEPTH are dropped and the
//   result's tuser bit reports it.
//   m_axis carries one result per load: the lower median of all 2n values.
//   After the final pair, s_axis_tready stays low until the search ends,
//   since the list memories are read by the search. The job is first popped
//   from the queue; each halving step is then a registered memory read
//   followed by a compare. A result waits in an output register while
//   m_axis_tready is low; the next load may be accepted meanwhile, and its
//   search starts once the output register is free.
//   Reset clears counts, queue and output valid; list memories are not
//   cleared and need not be.
`default_nettype none

module median_of_two_sorted_lists
    import med_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [2*DATA_W-1:0]  s_axis_tdata,   // value_b in upper half, value_a in lower half
    input  wire logic                 s_axis_tlast,   // last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [DATA_W-1:0]         m_axis_tdata,   // median
    output logic                      m_axis_tuser    // overflowed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW = AW + 1;

    logic          q_full, q_empty, q_push, q_pop;
    logic [JW-1:0] q_in, q_out;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    pair_t         wr_data;
    logic          unlock;

    med_front #(.DEPTH(DEPTH), .AW(AW), .JW(JW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (pair_t'(s_axis_tdata)),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .unlock        (unlock)
    );

    med_queue #(.W(JW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    med_back #(.DEPTH(DEPTH), .AW(AW), .JW(JW)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .unlock        (unlock),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/med_checker.sv =====
// Port-level checker for median_of_two_sorted_lists, bound to the top level.
// Depends on median_of_two_sorted_lists_macros.svh.
`default_nettype none

`include "median_of_two_sorted_lists_macros.svh"

module med_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    logic last_req;

    assign last_req = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    `MED_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `MED_ASSERT_NXT(a_lock_after_last, last_req, !s_axis_tready, "load accepted during search")

    `MED_ASSERT_IMP(a_no_early_result, $rose(m_axis_tvalid), !$past(last_req), "result too early")

endmodule

bind median_of_two_sorted_lists med_checker u_med_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
